FILE: rtl/u8xv_pkg.sv
// Package for the UTF-8 XML character validator.
// Holds the decoding constants, verdict codes and the XML character check.
// No dependencies.
`default_nettype none

package u8xv_pkg;

    localparam int unsigned CP_W = 21;

    typedef logic [CP_W-1:0] t_scalar;

    typedef enum logic [1:0] {
        VERDICT_OPEN   = 2'd0,
        VERDICT_VALID  = 2'd1,
        VERDICT_REJECT = 2'd2
    } t_verdict;

    localparam t_scalar CP_TAB        = 21'h00009;
    localparam t_scalar CP_LF         = 21'h0000A;
    localparam t_scalar CP_CR         = 21'h0000D;
    localparam t_scalar CP_SPACE      = 21'h00020;
    localparam t_scalar CP_BMP_LO_END = 21'h0D7FF;
    localparam t_scalar CP_BMP_HI     = 21'h0E000;
    localparam t_scalar CP_BMP_HI_END = 21'h0FFFD;
    localparam t_scalar CP_SUPP       = 21'h10000;
    localparam t_scalar CP_MAX        = 21'h10FFFF;
    localparam t_scalar MIN_LEN2      = 21'h00080;
    localparam t_scalar MIN_LEN3      = 21'h00800;
    localparam t_scalar MIN_LEN4      = 21'h10000;

    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_BITS  = 8'h3F;

    function automatic logic xml_char_ok(input t_scalar cp);
        return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
               (cp >= CP_SPACE && cp <= CP_BMP_LO_END) ||
               (cp >= CP_BMP_HI && cp <= CP_BMP_HI_END) ||
               (cp >= CP_SUPP && cp <= CP_MAX);
    endfunction

    function automatic t_scalar min_for_length(input logic [1:0] len);
        t_scalar m;
        unique case (len)
            2'd1:    m = MIN_LEN2;
            2'd2:    m = MIN_LEN3;
            default: m = MIN_LEN4;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_xml_char_validator.sv
// Top level of the UTF-8 XML character validator.
// Decodes one byte per item and checks each completed character; uses u8xv_pkg.
//
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_ready    i_data_byte, i_last_byte
// result   out        o_valid / i_ready    o_char_done, o_scalar, o_verdict,
//                                          o_error_seen
//
// Every accepted byte produces exactly one result item, presented in the cycle after acceptance.
// The decoder state and the result register update in the cycle of acceptance,
// so a new byte can be taken every cycle unless a held result is not being taken.
// o_ready is high whenever the result register is empty or is being taken.
// Reset is synchronous and active low; it clears the decoder state and o_valid.
`default_nettype none

module utf8_xml_char_validator
    import u8xv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_char_done,
    output logic [CP_W-1:0]        o_scalar,
    output logic [1:0]             o_verdict,
    output logic                   o_error_seen
);

    t_scalar     r_partial;
    logic [1:0]  r_bytes_pending;
    logic [1:0]  r_seq_len;
    logic        r_error_flag;

    t_scalar     n_partial;
    logic [1:0]  n_bytes_pending;
    logic [1:0]  n_seq_len;
    logic        n_error_flag;

    logic        r_out_valid;
    logic        r_char_done;
    t_scalar     r_scalar;
    t_verdict    r_verdict;
    logic        r_error_seen;

    logic        n_char_done;
    t_scalar     n_scalar;
    t_verdict    n_verdict;

    logic        accept;
    t_scalar     shifted;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign shifted = {r_partial[CP_W-7:0], i_data_byte[5:0] & MASK_BITS[5:0]};

    always_comb begin
        n_partial       = r_partial;
        n_bytes_pending = r_bytes_pending;
        n_seq_len       = r_seq_len;
        n_error_flag    = r_error_flag;
        n_char_done     = 1'b0;
        n_scalar        = '0;
        n_verdict       = VERDICT_OPEN;

        if (!r_error_flag) begin
            if (r_bytes_pending == 2'd0) begin
                priority if (!i_data_byte[7]) begin
                    if (xml_char_ok({13'd0, i_data_byte})) begin
                        n_char_done = 1'b1;
                        n_scalar    = {13'd0, i_data_byte};
                    end else begin
                        n_error_flag = 1'b1;
                    end
                end else if ((i_data_byte & MASK_LEAD2) == PAT_LEAD2) begin
                    n_partial       = {16'd0, i_data_byte[4:0]};
                    n_bytes_pending = 2'd1;
                    n_seq_len       = 2'd1;
                end else if ((i_data_byte & MASK_LEAD3) == PAT_LEAD3) begin
                    n_partial       = {17'd0, i_data_byte[3:0]};
                    n_bytes_pending = 2'd2;
                    n_seq_len       = 2'd2;
                end else if ((i_data_byte & MASK_LEAD4) == PAT_LEAD4) begin
                    n_partial       = {18'd0, i_data_byte[2:0]};
                    n_bytes_pending = 2'd3;
                    n_seq_len       = 2'd3;
                end else begin
                    n_error_flag = 1'b1;
                end
            end else if ((i_data_byte & MASK_CONT) != PAT_CONT) begin
                n_error_flag = 1'b1;
            end else begin
                n_partial       = shifted;
                n_bytes_pending = r_bytes_pending - 2'd1;
                if (r_bytes_pending == 2'd1) begin
                    if (shifted >= min_for_length(r_seq_len) && xml_char_ok(shifted)) begin
                        n_char_done = 1'b1;
                        n_scalar    = shifted;
                    end else begin
                        n_error_flag = 1'b1;
                    end
                end
            end
        end

        if (n_error_flag || n_char_done) begin
            n_partial       = '0;
            n_bytes_pending = 2'd0;
            n_seq_len       = 2'd0;
        end

        if (i_last_byte) begin
            if (n_bytes_pending != 2'd0) begin
                n_error_flag = 1'b1;
            end
            n_verdict = n_error_flag ? VERDICT_REJECT : VERDICT_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial       <= '0;
            r_bytes_pending <= 2'd0;
            r_seq_len       <= 2'd0;
            r_error_flag    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last_byte) begin
                    r_partial       <= '0;
                    r_bytes_pending <= 2'd0;
                    r_seq_len       <= 2'd0;
                    r_error_flag    <= 1'b0;
                end else begin
                    r_partial       <= n_partial;
                    r_bytes_pending <= n_bytes_pending;
                    r_seq_len       <= n_seq_len;
                    r_error_flag    <= n_error_flag;
                end
            end
            r_out_valid <= accept || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char_done  <= n_char_done;
            r_scalar     <= n_scalar;
            r_verdict    <= n_verdict;
            r_error_seen <= n_error_flag;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_char_done  = r_char_done;
    assign o_scalar     = r_scalar;
    assign o_verdict    = r_verdict;
    assign o_error_seen = r_error_seen;

    a_done_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_done) |-> !o_error_seen)
        else $error("character emitted together with an error");

    a_verdict_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != VERDICT_OPEN) |->
            (o_error_seen == (o_verdict == VERDICT_REJECT)))
        else $error("verdict disagrees with the error flag");

    a_idle_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_done) |-> (o_scalar == '0))
        else $error("scalar value nonzero without a character");

    a_pending_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_pending != 2'd0) |-> (!r_error_flag && r_bytes_pending <= r_seq_len))
        else $error("sequence state inconsistent");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_bytes_pending == 2'd0 && !r_error_flag))
        else $error("state not cleared after the last byte");

endmodule

`default_nettype wire
